// ----- sv/clqm_pkg.sv -----
`timescale 1ns / 1ps

package clqm_pkg;

    // Fixed field widths of the stream payloads.
    localparam int NODE_W     = 4;
    localparam int COUNT_W    = 5;
    localparam int STATUS_W   = 2;
    localparam int S_DATA_W   = 8;
    localparam int M_DATA_W   = 16;
    localparam int S_USER_W   = 1;

    // Default pool size; only slots that the index field can name get storage.
    localparam int POOL_NODES_DEFAULT = 16;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 2'd0,
        ST_LINKED     = 2'd1,
        ST_EMPTY      = 2'd2,
        ST_NOT_MEMBER = 2'd3
    } t_status;

    typedef enum logic {
        OP_APPEND = 1'b0,
        OP_REMOVE = 1'b1
    } t_op;

endpackage

// ----- sv/circular_linked_queue_manager.sv -----
`timescale 1ns / 1ps

// Channel   Dir  Handshake              Payload
// --------  ---  ---------------------  -----------------------------------------------
// s (ops)   in   i_s_tvalid/o_s_tready  tuser: operation; tdata: node_index
// m (res)   out  o_m_tvalid/i_m_tready  tdata: status, count, head_node, is_empty
//
// One operation per cycle is sustained while the result side does not stall; a result passes
// the operation register, then the link table logic, and is written to the result register.
// Reset (synchronous, active low) empties the queue and drops both pipeline registers.
// A stall on the result side holds the result and then the operation register in place.
// Link table entries get no reset; they are read only for slots that are linked.

module circular_linked_queue_manager
    import clqm_pkg::*;
#(
    parameter int POOL_NODES = POOL_NODES_DEFAULT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    // [3:0] node_index, [7:4] zero
    input  logic [S_DATA_W-1:0] i_s_tdata,
    // [0] operation
    input  logic [S_USER_W-1:0] i_s_tuser,
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    // [1:0] status, [6:2] count, [10:7] head_node, [11] is_empty, [15:12] zero
    output logic [M_DATA_W-1:0] o_m_tdata
);

    // Slots reachable through the index field.
    localparam int MAX_SLOTS = 1 << NODE_W;
    localparam int SLOTS     = (POOL_NODES < MAX_SLOTS) ? POOL_NODES : MAX_SLOTS;
    localparam int SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W     = $clog2(SLOTS + 1);

    // Operation register.
    logic              r_in_valid;
    t_op               r_op;
    logic [NODE_W-1:0] r_idx;

    // Queue state. The tail register mirrors prev_link of the head, so an
    // append needs no table read at all.
    logic [SLOT_W-1:0] r_next [SLOTS];
    logic [SLOT_W-1:0] r_prev [SLOTS];
    logic [SLOTS-1:0]  r_linked;
    logic [SLOT_W-1:0] r_head;
    logic [SLOT_W-1:0] r_tail;
    logic [CNT_W-1:0]  r_count;

    // Result register.
    logic                r_out_valid;
    logic [M_DATA_W-1:0] r_out_data;

    logic              w_advance;
    logic              w_in_pool;
    logic [SLOT_W-1:0] w_slot;
    logic              w_is_linked;
    logic [SLOT_W-1:0] w_pred;
    logic [SLOT_W-1:0] w_succ;
    t_status           w_status;
    logic              w_do_append;
    logic              w_do_remove;
    logic [CNT_W-1:0]  n_count;
    logic [SLOT_W-1:0] n_head;
    logic              w_empty_after;
    logic [NODE_W-1:0] w_head_field;

    // The operation register moves on whenever the result register is free or
    // is being drained in this same cycle.
    assign w_advance  = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || w_advance;

    assign w_in_pool   = {1'b0, r_idx} < (NODE_W + 1)'(SLOTS);
    assign w_slot      = r_idx[SLOT_W-1:0];
    assign w_is_linked = w_in_pool && r_linked[w_slot];
    assign w_pred      = r_prev[w_slot];
    assign w_succ      = r_next[w_slot];

    always_comb begin
        w_status = ST_OK;
        if (r_op == OP_APPEND) begin
            if (!w_in_pool) begin
                w_status = ST_NOT_MEMBER;
            end else if (w_is_linked) begin
                w_status = ST_LINKED;
            end
        end else begin
            // An empty queue is reported before the membership check.
            if (r_count == '0) begin
                w_status = ST_EMPTY;
            end else if (!w_is_linked) begin
                w_status = ST_NOT_MEMBER;
            end
        end
    end

    assign w_do_append = w_advance && (r_op == OP_APPEND) && (w_status == ST_OK);
    assign w_do_remove = w_advance && (r_op == OP_REMOVE) && (w_status == ST_OK);

    always_comb begin
        n_count = r_count;
        n_head  = r_head;
        if (w_do_append) begin
            n_count = r_count + 1'b1;
            if (r_count == '0) begin
                n_head = w_slot;
            end
        end else if (w_do_remove) begin
            n_count = r_count - 1'b1;
            if (r_count == CNT_W'(1)) begin
                n_head = '0;
            end else if (r_head == w_slot) begin
                n_head = w_succ;
            end
        end
    end

    assign w_empty_after = (n_count == '0);
    assign w_head_field  = w_empty_after ? '0 : NODE_W'(n_head);

    // Control state and the queue bookkeeping.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_linked    <= '0;
            r_head      <= '0;
            r_count     <= '0;
        end else begin
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            if (w_do_append) begin
                r_linked[w_slot] <= 1'b1;
            end else if (w_do_remove) begin
                r_linked[w_slot] <= 1'b0;
            end
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    // Payload registers and link tables, no reset.
    always_ff @(posedge i_clk) begin
        if (o_s_tready) begin
            r_op  <= t_op'(i_s_tuser[0]);
            r_idx <= i_s_tdata[NODE_W-1:0];
        end
        if (w_advance) begin
            r_out_data <= {
                (M_DATA_W - STATUS_W - COUNT_W - NODE_W - 1)'(0),
                w_empty_after,
                w_head_field,
                COUNT_W'(n_count),
                w_status
            };
        end
        if (w_do_append) begin
            r_tail <= w_slot;
            if (r_count == '0) begin
                // A lone node links to itself.
                r_next[w_slot] <= w_slot;
                r_prev[w_slot] <= w_slot;
            end else begin
                // Splice in between the tail and the head.
                r_next[w_slot] <= r_head;
                r_prev[w_slot] <= r_tail;
                r_prev[r_head] <= w_slot;
                r_next[r_tail] <= w_slot;
            end
        end else if (w_do_remove && (r_count != CNT_W'(1))) begin
            r_next[w_pred] <= w_succ;
            r_prev[w_succ] <= w_pred;
            if (r_tail == w_slot) begin
                r_tail <= w_pred;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

`ifndef ASSERT_OFF
    // The running count always agrees with the number of linked slots.
    a_count_matches_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_linked) == int'(r_count))
        else $error("node count differs from linked flags");

    // A successful remove takes exactly one node off the count.
    a_remove_decrements: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && w_do_remove) |=> (r_count == $past(r_count) - 1'b1))
        else $error("remove did not decrement the count");

    // An empty queue keeps its head slot cleared.
    a_empty_head_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_head == '0))
        else $error("head not cleared while empty");

    // A result is never overwritten while it waits on the master side.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_tready) |-> !w_advance)
        else $error("result register overwritten during stall");
`endif

endmodule
